>>> rtl/u8dec_pkg.sv
// Package for the extended UTF-8 decoder: item types, status codes and lead-byte helpers.
`default_nettype none
package u8dec_pkg;

    localparam int unsigned CpW = 31;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_MALFORMED = 2'd1;
    localparam logic [1:0] ST_PARTIAL   = 2'd2;

    localparam logic [7:0]  CONT_MASK  = 8'hC0;
    localparam logic [7:0]  CONT_TAG   = 8'h80;
    localparam logic [15:0] HI_BASE    = 16'hD7C0; // 0xD800 - (0x10000 >> 10)
    localparam logic [5:0]  LO_TAG     = 6'b110111; // 0xDC00 >> 10
    localparam logic [CpW-1:0] BMP_TOP = CpW'(32'h0001_0000);

    typedef struct packed {
        logic [7:0] byte_lead;
        logic [7:0] byte_second;
        logic [7:0] byte_third;
        logic [7:0] byte_fourth;
        logic [7:0] byte_fifth;
        logic [7:0] byte_sixth;
        logic [2:0] avail_bytes;
    } t_in_item;

    typedef struct packed {
        logic [CpW-1:0] code_point;
        logic [1:0]     status;
        logic [2:0]     seq_length;
        logic [1:0]     unit_count;
        logic [15:0]    unit_first;
        logic [15:0]    unit_second;
    } t_out_item;

    // Skip length of a lead byte, given whatever the status is.
    function automatic logic [2:0] skip_len(input logic [7:0] b);
        logic [2:0] n;
        n = 3'd1;
        case (b) inside
            [8'hC0:8'hDF]: n = 3'd2;
            [8'hE0:8'hEF]: n = 3'd3;
            [8'hF0:8'hF7]: n = 3'd4;
            [8'hF8:8'hFB]: n = 3'd5;
            [8'hFC:8'hFD]: n = 3'd6;
            default:       n = 3'd1;
        endcase
        return n;
    endfunction

    // Least code point that a sequence of the given length may carry.
    function automatic logic [CpW-1:0] least_value(input logic [2:0] len);
        logic [CpW-1:0] m;
        m = '0;
        case (len)
            3'd2:    m = CpW'(32'h0000_0080);
            3'd3:    m = CpW'(32'h0000_0800);
            3'd4:    m = CpW'(32'h0001_0000);
            3'd5:    m = CpW'(32'h0020_0000);
            3'd6:    m = CpW'(32'h0400_0000);
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage
`default_nettype wire

>>> rtl/utf8_decoder_utf16_split.sv
// Top level: three-stage pipelined extended UTF-8 decoder with UTF-16 split.
//
//  channel   direction  handshake                    payload
//  -------   ---------  ---------------------------  --------------------------------
//  input     in         i_in_valid / o_in_stall      i_in_data  (u8dec_pkg::t_in_item)
//  output    out        o_out_valid / i_out_stall    o_out_data (u8dec_pkg::t_out_item)
//
//  One transaction enters per cycle unless an output stall backs up to the input.
//  Stage 1 classifies the lead byte and tests the continuation bytes, stage 2
//  resolves the status and assembles the code point, stage 3 checks for an
//  overlong form and splits into UTF-16 units; its register drives the output.
//  A stage takes a new transaction whenever it is empty or the next stage takes
//  its own, so bubbles collapse and a stall holds each full stage with no bubble ahead.
//  Reset clears the valid bits only; the data registers need no reset.
`default_nettype none
module utf8_decoder_utf16_split (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire u8dec_pkg::t_in_item   i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output u8dec_pkg::t_out_item       o_out_data
);

    localparam int unsigned CpW = u8dec_pkg::CpW;

    // ---------------------------------------------------------------
    // Flow control: each stage advances when empty or when drained.
    // ---------------------------------------------------------------
    logic r1_valid, r2_valid, r3_valid;
    logic n1_valid, n2_valid, n3_valid;
    logic take1, take2, take3;

    assign take3 = !r3_valid || !i_out_stall;
    assign take2 = !r2_valid || take3;
    assign take1 = !r1_valid || take2;
    assign o_in_stall = !take1;

    assign n1_valid = take1 ? i_in_valid : r1_valid;
    assign n2_valid = take2 ? r1_valid   : r2_valid;
    assign n3_valid = take3 ? r2_valid   : r3_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            r1_valid <= n1_valid;
            r2_valid <= n2_valid;
            r3_valid <= n3_valid;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: classify lead, clamp avail, flag continuation bytes.
    // ---------------------------------------------------------------
    logic [7:0]      bytes_in [1:5];
    logic [2:0]      n1_len;
    logic            n1_bad;
    logic [2:0]      n1_avail;
    logic [5:1]      n1_cont;
    logic [5:1]      n1_zero;

    logic [7:0]      r1_lead;
    logic [5:0]      r1_low [1:5];
    logic [2:0]      r1_len;
    logic            r1_bad;
    logic [2:0]      r1_skip;
    logic [2:0]      r1_avail;
    logic [5:1]      r1_cont;
    logic [5:1]      r1_zero;

    assign bytes_in[1] = i_in_data.byte_second;
    assign bytes_in[2] = i_in_data.byte_third;
    assign bytes_in[3] = i_in_data.byte_fourth;
    assign bytes_in[4] = i_in_data.byte_fifth;
    assign bytes_in[5] = i_in_data.byte_sixth;

    always_comb begin
        n1_bad = 1'b0;
        n1_len = 3'd1;
        case (i_in_data.byte_lead) inside
            [8'h00:8'h7F]: n1_len = 3'd1;
            [8'h80:8'hBF]: n1_bad = 1'b1;
            [8'hC0:8'hDF]: n1_len = 3'd2;
            [8'hE0:8'hEF]: n1_len = 3'd3;
            [8'hF0:8'hF7]: n1_len = 3'd4;
            [8'hF8:8'hFB]: n1_len = 3'd5;
            [8'hFC:8'hFD]: n1_len = 3'd6;
            default:       n1_bad = 1'b1;
        endcase
        // Treat an avail count of seven as unlimited, same as six.
        n1_avail = (i_in_data.avail_bytes == 3'd7) ? 3'd6 : i_in_data.avail_bytes;
        for (int i = 1; i <= 5; i++) begin
            n1_cont[i] = (bytes_in[i] & u8dec_pkg::CONT_MASK) == u8dec_pkg::CONT_TAG;
            n1_zero[i] = bytes_in[i] == 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take1) begin
            r1_lead  <= i_in_data.byte_lead;
            r1_len   <= n1_len;
            r1_bad   <= n1_bad;
            r1_skip  <= u8dec_pkg::skip_len(i_in_data.byte_lead);
            r1_avail <= n1_avail;
            r1_cont  <= n1_cont;
            r1_zero  <= n1_zero;
            for (int i = 1; i <= 5; i++) begin
                r1_low[i] <= bytes_in[i][5:0];
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: resolve status, assemble code point.
    // ---------------------------------------------------------------
    logic [1:0]      n2_status;
    logic [CpW-1:0]  n2_wc;
    logic            n2_chk;

    logic [1:0]      r2_status;
    logic [CpW-1:0]  r2_wc;
    logic            r2_chk;
    logic [2:0]      r2_len;
    logic [2:0]      r2_skip;

    always_comb begin
        logic found;
        found     = 1'b0;
        n2_status = u8dec_pkg::ST_OK;
        n2_chk    = 1'b0;
        if (r1_bad) begin
            n2_status = u8dec_pkg::ST_MALFORMED;
        end else if (r1_len > 3'd1) begin
            if (r1_len > r1_avail) begin
                // Truncated window: any non-continuation in range is malformed.
                n2_status = u8dec_pkg::ST_PARTIAL;
                for (int i = 1; i <= 5; i++) begin
                    if (!found && (3'(i) < r1_avail) && !r1_cont[i]) begin
                        n2_status = u8dec_pkg::ST_MALFORMED;
                        found     = 1'b1;
                    end
                end
            end else begin
                // Full sequence: first bad continuation decides; zero byte is partial.
                for (int i = 1; i <= 5; i++) begin
                    if (!found && (3'(i) < r1_len) && !r1_cont[i]) begin
                        n2_status = r1_zero[i] ? u8dec_pkg::ST_PARTIAL
                                               : u8dec_pkg::ST_MALFORMED;
                        found     = 1'b1;
                    end
                end
                n2_chk = !found;
            end
        end

        case (r1_len)
            3'd2:    n2_wc = CpW'({r1_lead[4:0], r1_low[1]});
            3'd3:    n2_wc = CpW'({r1_lead[3:0], r1_low[1], r1_low[2]});
            3'd4:    n2_wc = CpW'({r1_lead[2:0], r1_low[1], r1_low[2], r1_low[3]});
            3'd5:    n2_wc = CpW'({r1_lead[1:0], r1_low[1], r1_low[2], r1_low[3],
                                   r1_low[4]});
            3'd6:    n2_wc = {r1_lead[0], r1_low[1], r1_low[2], r1_low[3], r1_low[4],
                              r1_low[5]};
            default: n2_wc = CpW'(r1_lead[6:0]);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (take2) begin
            r2_status <= n2_status;
            r2_wc     <= n2_wc;
            r2_chk    <= n2_chk;
            r2_len    <= r1_len;
            r2_skip   <= r1_skip;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: overlong check, UTF-16 split, output register.
    // ---------------------------------------------------------------
    logic [1:0]            st3;
    u8dec_pkg::t_out_item  n3_data;
    u8dec_pkg::t_out_item  r3_data;

    always_comb begin
        st3 = r2_status;
        if (r2_chk && (r2_wc < u8dec_pkg::least_value(r2_len))) begin
            st3 = u8dec_pkg::ST_MALFORMED;
        end
        n3_data             = '0;
        n3_data.status      = st3;
        n3_data.seq_length  = r2_skip;
        if (st3 == u8dec_pkg::ST_OK) begin
            n3_data.code_point = r2_wc;
            if (r2_wc < u8dec_pkg::BMP_TOP) begin
                n3_data.unit_count = 2'd1;
                n3_data.unit_first = r2_wc[15:0];
            end else begin
                // High unit: ((wc - 0x10000) >> 10) + 0xD800, kept to 16 bits.
                n3_data.unit_count  = 2'd2;
                n3_data.unit_first  = r2_wc[25:10] + u8dec_pkg::HI_BASE;
                n3_data.unit_second = {u8dec_pkg::LO_TAG, r2_wc[9:0]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take3) begin
            r3_data <= n3_data;
        end
    end

    assign o_out_valid = r3_valid;
    assign o_out_data  = r3_data;

endmodule
`default_nettype wire

>>> tb/tb_utf8_decoder_utf16_split.sv
// Self-checking testbench for the extended UTF-8 decoder with UTF-16 split.
module tb_utf8_decoder_utf16_split;

    localparam int unsigned CYCLE_LIMIT  = 400_000;
    localparam int unsigned HOLD_CYCLES  = 200;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int          PHASE_ITEMS  = 350;

    // Scoreboard: predict each accepted window, compare each result in order.
    class decode_board;
        u8dec_pkg::t_out_item pending_results[$];
        int unsigned          fail_count;

        function new();
            fail_count = 0;
        endfunction

        function void report(string what);
            fail_count++;
            $display("[%0t] mismatch: %s", $time, what);
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // Decode one window the way the block must: classify the lead byte,
        // walk the continuation bytes, reject overlong forms, then split.
        function u8dec_pkg::t_out_item decode_window(u8dec_pkg::t_in_item w);
            logic [7:0]  b [6];
            logic [2:0]  avail;
            logic [31:0] cp, floor_cp, v;
            logic [1:0]  st;
            int          len, i;
            bit          scanning;
            u8dec_pkg::t_out_item r;
            b[0] = w.byte_lead;
            b[1] = w.byte_second;
            b[2] = w.byte_third;
            b[3] = w.byte_fourth;
            b[4] = w.byte_fifth;
            b[5] = w.byte_sixth;
            // A count of seven means an unlimited window, same as six.
            avail = (w.avail_bytes == 3'd7) ? 3'd6 : w.avail_bytes;
            st = u8dec_pkg::ST_OK;
            len = 0;
            cp = '0;
            floor_cp = '0;
            if (b[0] < 8'h80) begin
                cp = {24'd0, b[0]};
                len = 1;
            end else if (b[0] < 8'hC0) begin
                st = u8dec_pkg::ST_MALFORMED;
            end else if (b[0] < 8'hE0) begin
                len = 2; cp = {27'd0, b[0][4:0]}; floor_cp = 32'h80;
            end else if (b[0] < 8'hF0) begin
                len = 3; cp = {28'd0, b[0][3:0]}; floor_cp = 32'h800;
            end else if (b[0] < 8'hF8) begin
                len = 4; cp = {29'd0, b[0][2:0]}; floor_cp = 32'h1_0000;
            end else if (b[0] < 8'hFC) begin
                len = 5; cp = {30'd0, b[0][1:0]}; floor_cp = 32'h20_0000;
            end else if (b[0] < 8'hFE) begin
                len = 6; cp = {31'd0, b[0][0]}; floor_cp = 32'h400_0000;
            end else begin
                st = u8dec_pkg::ST_MALFORMED;
            end

            if (st == u8dec_pkg::ST_OK && len > 1) begin
                scanning = 1'b1;
                if (len > avail) begin
                    // Truncated window: only the bytes present can condemn it.
                    st = u8dec_pkg::ST_PARTIAL;
                    for (i = 1; i < avail; i++) begin
                        if (scanning && (b[i] & 8'hC0) != 8'h80) begin
                            st = u8dec_pkg::ST_MALFORMED;
                            scanning = 1'b0;
                        end
                    end
                end else begin
                    for (i = 1; i < len; i++) begin
                        if (scanning) begin
                            if ((b[i] & 8'hC0) != 8'h80) begin
                                st = (b[i] == 8'h00) ? u8dec_pkg::ST_PARTIAL
                                                     : u8dec_pkg::ST_MALFORMED;
                                scanning = 1'b0;
                            end else begin
                                cp = (cp << 6) | {26'd0, b[i][5:0]};
                            end
                        end
                    end
                    if (st == u8dec_pkg::ST_OK && cp < floor_cp)
                        st = u8dec_pkg::ST_MALFORMED;
                end
            end

            r = '0;
            r.status     = st;
            r.seq_length = (len == 0) ? 3'd1 : 3'(len);
            if (st == u8dec_pkg::ST_OK) begin
                r.code_point = cp[30:0];
                if (cp < 32'h1_0000) begin
                    r.unit_count = 2'd1;
                    r.unit_first = cp[15:0];
                end else begin
                    v = cp - 32'h1_0000;
                    r.unit_count  = 2'd2;
                    r.unit_first  = 16'((v >> 10) + 32'hD800);
                    r.unit_second = 16'((v & 32'h3FF) + 32'hDC00);
                end
            end
            return r;
        endfunction

        function void note_window(u8dec_pkg::t_in_item w);
            pending_results.push_back(decode_window(w));
        endfunction

        function void check_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("%s got %0h expected %0h", name, got, want));
        endfunction

        function void check_result(u8dec_pkg::t_out_item got);
            u8dec_pkg::t_out_item want;
            if (pending_results.size() == 0) begin
                report("result with no window pending");
            end else begin
                want = pending_results.pop_front();
                check_field("code_point",  32'(got.code_point),  32'(want.code_point));
                check_field("status",      32'(got.status),      32'(want.status));
                check_field("seq_length",  32'(got.seq_length),  32'(want.seq_length));
                check_field("unit_count",  32'(got.unit_count),  32'(want.unit_count));
                check_field("unit_first",  32'(got.unit_first),  32'(want.unit_first));
                check_field("unit_second", 32'(got.unit_second), 32'(want.unit_second));
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    u8dec_pkg::t_in_item  i_in_data;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic                 i_out_stall;
    u8dec_pkg::t_out_item o_out_data;

    decode_board board;
    bit          sender_idles;
    bit          receiver_idles;
    bit          hold_request;
    int unsigned cycle_count;

    utf8_decoder_utf16_split uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watch both channels at the rising edge: a transaction moves when valid
    // is high and stall is low.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (i_in_valid && o_in_stall === 1'b0)
                board.note_window(i_in_data);
            if (o_out_valid === 1'b1 && !i_out_stall)
                board.check_result(o_out_data);
        end
    end

    // Pack six bytes and a count into one input transaction.
    function automatic u8dec_pkg::t_in_item window(input logic [7:0] b0,
                                                   input logic [7:0] b1,
                                                   input logic [7:0] b2,
                                                   input logic [7:0] b3,
                                                   input logic [7:0] b4,
                                                   input logic [7:0] b5,
                                                   input logic [2:0] avail);
        u8dec_pkg::t_in_item w;
        w.byte_lead   = b0;
        w.byte_second = b1;
        w.byte_third  = b2;
        w.byte_fourth = b3;
        w.byte_fifth  = b4;
        w.byte_sixth  = b5;
        w.avail_bytes = avail;
        return w;
    endfunction

    // Mostly well-formed characters of random length and value; the rest are
    // overlong forms, broken continuations and plain noise.
    function automatic u8dec_pkg::t_in_item random_window();
        logic [7:0]  b [6];
        logic [7:0]  prefix;
        logic [31:0] cp, lo, hi;
        int          len, k, kind, avail;
        for (k = 0; k < 6; k++)
            b[k] = 8'($urandom);
        kind  = $urandom_range(0, 99);
        len   = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 6) : $urandom_range(1, 3);
        avail = $urandom_range(0, 7);
        if (kind < 85) begin
            case (len)
                1: begin lo = 32'h0;        hi = 32'h7F;        prefix = 8'h00; end
                2: begin lo = 32'h80;       hi = 32'h7FF;       prefix = 8'hC0; end
                3: begin lo = 32'h800;      hi = 32'hFFFF;      prefix = 8'hE0; end
                4: begin lo = 32'h1_0000;   hi = 32'h1F_FFFF;   prefix = 8'hF0; end
                5: begin lo = 32'h20_0000;  hi = 32'h3FF_FFFF;  prefix = 8'hF8; end
                default: begin lo = 32'h400_0000; hi = 32'h7FFF_FFFF; prefix = 8'hFC; end
            endcase
            if (kind >= 75 && len > 1)
                cp = $urandom_range(0, lo - 1);
            else if ($urandom_range(0, 7) == 0)
                cp = $urandom_range(0, 1) ? lo : hi;
            else
                cp = $urandom_range(lo, hi);
            b[0] = prefix | 8'(cp >> (6 * (len - 1)));
            for (k = 1; k < len; k++)
                b[k] = 8'h80 | 8'((cp >> (6 * (len - 1 - k))) & 32'h3F);
            // Break one continuation byte, sometimes with a zero byte.
            if (kind >= 60 && kind < 75 && len > 1) begin
                k = $urandom_range(1, len - 1);
                if ($urandom_range(0, 2) == 0)
                    b[k] = 8'h00;
                else if ((b[k] & 8'hC0) == 8'h80)
                    b[k] = b[k] ^ 8'h40;
            end
            avail = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7)
                                                : $urandom_range(len, 7);
        end
        return window(b[0], b[1], b[2], b[3], b[4], b[5], 3'(avail));
    endfunction

    // Offer one transaction, after a random gap when the sender idles; hold it until accepted.
    // Enter and leave at the falling edge so valid is never dropped and
    // raised in the same step.
    task automatic offer_window(input u8dec_pkg::t_in_item w);
        int gap;
        gap = sender_idles ? $urandom_range(0, 16) : 0;
        if (gap != 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data  = w;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        @(negedge i_clk);
    endtask

    // Stop offering and wait until every predicted result has come back.
    task automatic wait_drained();
        i_in_valid = 1'b0;
        while (board.pending() != 0)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Result side: when the receiver idles, stall a random number of cycles before each result, or
    // hold off for a long stretch when asked so the pipeline backs up.
    initial begin : result_sink
        int waits;
        i_out_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            waits = receiver_idles ? $urandom_range(0, 16) : 0;
            if (waits != 0) begin
                i_out_stall = 1'b1;
                repeat (waits) @(negedge i_clk);
            end
            i_out_stall = 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            @(negedge i_clk);
        end
    end

    // Bound the run; a hung handshake ends here.
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        int phase, n;
        board          = new();
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_data      = '0;
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        hold_request   = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // ASCII leads pass at once, even with an empty window.
        offer_window(window(8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd0));
        offer_window(window(8'h7F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0));
        // Bad lead bytes: stray continuations and the two never-lead codes.
        offer_window(window(8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 3'd6));
        offer_window(window(8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 3'd6));
        offer_window(window(8'hFE, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 3'd6));
        offer_window(window(8'hFF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 3'd6));
        // Each multi-byte length with typical values, plus the extreme legal values of the longer forms.
        offer_window(window(8'hC2, 8'hA9, 8'h00, 8'h00, 8'h00, 8'h00, 3'd2));
        offer_window(window(8'hE2, 8'h82, 8'hAC, 8'h00, 8'h00, 8'h00, 3'd3));
        offer_window(window(8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'h00, 8'h00, 3'd4));
        offer_window(window(8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'h00, 8'h00, 3'd6));
        offer_window(window(8'hF8, 8'h88, 8'h80, 8'h80, 8'h80, 8'h00, 3'd5));
        offer_window(window(8'hFB, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'h00, 3'd5));
        offer_window(window(8'hFC, 8'h84, 8'h80, 8'h80, 8'h80, 8'h80, 3'd6));
        offer_window(window(8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 3'd6));
        // Surrogate value passes as a single unit.
        offer_window(window(8'hED, 8'hA0, 8'h80, 8'h00, 8'h00, 8'h00, 3'd3));
        // Overlong forms.
        offer_window(window(8'hC0, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 3'd6));
        offer_window(window(8'hE0, 8'h9F, 8'hBF, 8'h00, 8'h00, 8'h00, 3'd6));
        offer_window(window(8'hF8, 8'h87, 8'hBF, 8'hBF, 8'hBF, 8'h00, 3'd6));
        // Truncated windows: clean tail, bad tail, one byte, no bytes.
        offer_window(window(8'hE2, 8'h82, 8'hAC, 8'h00, 8'h00, 8'h00, 3'd2));
        offer_window(window(8'hE2, 8'h41, 8'hAC, 8'h00, 8'h00, 8'h00, 3'd2));
        offer_window(window(8'hF0, 8'h9F, 8'h98, 8'h80, 8'h00, 8'h00, 3'd1));
        offer_window(window(8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 3'd0));
        // Zero continuation reads as partial, any other bad byte as malformed.
        offer_window(window(8'hE2, 8'h00, 8'hAC, 8'h00, 8'h00, 8'h00, 3'd6));
        offer_window(window(8'hE2, 8'h82, 8'hC0, 8'h00, 8'h00, 8'h00, 3'd3));
        // Oversized count behaves as unlimited; pair of surrogates out.
        offer_window(window(8'hF0, 8'h9F, 8'h98, 8'h80, 8'h00, 8'h00, 3'd7));
        wait_drained();

        // Phases: both sides idle, no idling with a long hold-off on the
        // result side, then each side idling alone. Drain between phases.
        for (phase = 0; phase < 4; phase++) begin
            sender_idles   = (phase == 0 || phase == 2);
            receiver_idles = (phase == 0 || phase == 3);
            if (phase == 1)
                hold_request = 1'b1;
            for (n = 0; n < PHASE_ITEMS; n++)
                offer_window(random_window());
            wait_drained();
        end

        // Let any stray result surface before the verdict.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
